// ===== src/hkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hkc_pkg;

	localparam logic [15:0] SylBase     = 16'hAC00;
	localparam logic [15:0] SylPerInit  = 16'd588;
	localparam logic [15:0] SylPerMed   = 16'd28;
	localparam logic [15:0] VowelBase   = 16'h314F;

	localparam logic [7:0] KeyBackspace = 8'd8;
	localparam logic [7:0] KeyTab       = 8'd9;
	localparam logic [7:0] KeySpace     = 8'd32;

	localparam logic [1:0] RegNumbersOnly    = 2'd0;
	localparam logic [1:0] RegNumbersAllowed = 2'd1;
	localparam logic [1:0] RegModeSwitch     = 2'd2;
	localparam logic [1:0] RegStartMode      = 2'd3;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_ERASE  = 1'b1
	} edit_op_t;

	typedef enum logic {
		MODE_HANGUL  = 1'b0,
		MODE_ENGLISH = 1'b1
	} input_mode_t;

	typedef enum logic [2:0] {
		LV_IDLE     = 3'd0,
		LV_INITIAL  = 3'd1,
		LV_MEDIAL   = 3'd2,
		LV_CMEDIAL  = 3'd3,
		LV_FINAL    = 3'd4,
		LV_CFINAL   = 3'd5,
		LV_VOWEL    = 3'd6
	} level_t;

	typedef struct packed {
		edit_op_t    op;
		logic [15:0] cp;
	} cmd_t;

	// one key's worth of commands, cnt is 1..3
	typedef struct packed {
		logic [1:0] cnt;
		cmd_t [2:0] cmd;
	} entry_t;

	typedef struct packed {
		logic       vowel;
		logic [4:0] idx;
	} letter_t;

	function automatic letter_t letter_info(input logic [4:0] l, input logic sh);
		letter_t r;
		r = '{vowel: 1'b0, idx: 5'd0};
		case (l)
			5'd0:  r = '{1'b0, 5'd6};
			5'd1:  r = '{1'b1, 5'd17};
			5'd2:  r = '{1'b0, 5'd14};
			5'd3:  r = '{1'b0, 5'd11};
			5'd4:  r = '{1'b0, sh ? 5'd4 : 5'd3};
			5'd5:  r = '{1'b0, 5'd5};
			5'd6:  r = '{1'b0, 5'd18};
			5'd7:  r = '{1'b1, 5'd8};
			5'd8:  r = '{1'b1, 5'd2};
			5'd9:  r = '{1'b1, 5'd4};
			5'd10: r = '{1'b1, 5'd0};
			5'd11: r = '{1'b1, 5'd20};
			5'd12: r = '{1'b1, 5'd18};
			5'd13: r = '{1'b1, 5'd13};
			5'd14: r = '{1'b1, sh ? 5'd3 : 5'd1};
			5'd15: r = '{1'b1, sh ? 5'd7 : 5'd5};
			5'd16: r = '{1'b0, sh ? 5'd8 : 5'd7};
			5'd17: r = '{1'b0, sh ? 5'd1 : 5'd0};
			5'd18: r = '{1'b0, 5'd2};
			5'd19: r = '{1'b0, sh ? 5'd10 : 5'd9};
			5'd20: r = '{1'b1, 5'd6};
			5'd21: r = '{1'b0, 5'd17};
			5'd22: r = '{1'b0, sh ? 5'd13 : 5'd12};
			5'd23: r = '{1'b0, 5'd16};
			5'd24: r = '{1'b1, 5'd12};
			5'd25: r = '{1'b0, 5'd15};
			default: r = '{1'b0, 5'd0};
		endcase
		return r;
	endfunction

	function automatic logic [15:0] cons_cp(input logic [4:0] t);
		logic [15:0] r;
		case (t)
			5'd0:  r = 16'h3131;  5'd1:  r = 16'h3132;  5'd2:  r = 16'h3134;
			5'd3:  r = 16'h3137;  5'd4:  r = 16'h3138;  5'd5:  r = 16'h3139;
			5'd6:  r = 16'h3141;  5'd7:  r = 16'h3142;  5'd8:  r = 16'h3143;
			5'd9:  r = 16'h3145;  5'd10: r = 16'h3146;  5'd11: r = 16'h3147;
			5'd12: r = 16'h3148;  5'd13: r = 16'h3149;  5'd14: r = 16'h314A;
			5'd15: r = 16'h314B;  5'd16: r = 16'h314C;  5'd17: r = 16'h314D;
			5'd18: r = 16'h314E;
			default: r = 16'h3131;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] init_to_final(input logic [4:0] t);
		logic [4:0] r;
		case (t)
			5'd0: r = 5'd1;   5'd1: r = 5'd2;   5'd2: r = 5'd4;   5'd3: r = 5'd7;
			5'd5: r = 5'd8;   5'd6: r = 5'd16;  5'd7: r = 5'd17;  5'd9: r = 5'd19;
			5'd10: r = 5'd20; 5'd11: r = 5'd21; 5'd12: r = 5'd22; 5'd14: r = 5'd23;
			5'd15: r = 5'd24; 5'd16: r = 5'd25; 5'd17: r = 5'd26; 5'd18: r = 5'd27;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] final_to_init(input logic [4:0] f);
		logic [4:0] r;
		case (f)
			5'd2: r = 5'd1;   5'd4: r = 5'd2;   5'd7: r = 5'd3;   5'd8: r = 5'd5;
			5'd16: r = 5'd6;  5'd17: r = 5'd7;  5'd19: r = 5'd9;  5'd20: r = 5'd10;
			5'd21: r = 5'd11; 5'd22: r = 5'd12; 5'd23: r = 5'd14; 5'd24: r = 5'd15;
			5'd25: r = 5'd16; 5'd26: r = 5'd17; 5'd27: r = 5'd18;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// compound final from a final and an added initial, 0 when none
	function automatic logic [4:0] fin_join(input logic [4:0] f, input logic [4:0] t);
		logic [4:0] r;
		r = 5'd0;
		case ({f, t})
			{5'd1, 5'd9}:   r = 5'd3;
			{5'd4, 5'd12}:  r = 5'd5;
			{5'd4, 5'd18}:  r = 5'd6;
			{5'd8, 5'd0}:   r = 5'd9;
			{5'd8, 5'd6}:   r = 5'd10;
			{5'd8, 5'd7}:   r = 5'd11;
			{5'd8, 5'd9}:   r = 5'd12;
			{5'd8, 5'd16}:  r = 5'd13;
			{5'd8, 5'd17}:  r = 5'd14;
			{5'd8, 5'd18}:  r = 5'd15;
			{5'd17, 5'd9}:  r = 5'd18;
			default:        r = 5'd0;
		endcase
		return r;
	endfunction

	// compound final split: {first final, moved initial}
	function automatic logic [9:0] fin_split(input logic [4:0] f);
		logic [9:0] r;
		case (f)
			5'd3:  r = {5'd1, 5'd9};
			5'd5:  r = {5'd4, 5'd12};
			5'd6:  r = {5'd4, 5'd18};
			5'd9:  r = {5'd8, 5'd0};
			5'd10: r = {5'd8, 5'd6};
			5'd11: r = {5'd8, 5'd7};
			5'd12: r = {5'd8, 5'd9};
			5'd13: r = {5'd8, 5'd16};
			5'd14: r = {5'd8, 5'd17};
			5'd15: r = {5'd8, 5'd18};
			5'd18: r = {5'd17, 5'd9};
			default: r = {f, 5'd0};
		endcase
		return r;
	endfunction

	function automatic logic [4:0] vow_join(input logic [4:0] m, input logic [4:0] t);
		logic [4:0] r;
		case ({m, t})
			{5'd8, 5'd0}:   r = 5'd9;
			{5'd8, 5'd1}:   r = 5'd10;
			{5'd8, 5'd20}:  r = 5'd11;
			{5'd13, 5'd4}:  r = 5'd14;
			{5'd13, 5'd5}:  r = 5'd15;
			{5'd13, 5'd20}: r = 5'd16;
			{5'd18, 5'd20}: r = 5'd19;
			default:        r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] syllable(input logic [4:0] a, input logic [4:0] b,
		input logic [4:0] c);
		return SylBase + 16'(a) * SylPerInit + 16'(b) * SylPerMed + 16'(c);
	endfunction

endpackage
`default_nettype wire

// ===== src/hangul_two_set_key_composer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// two-set hangul keyboard composer: every key word on the slave side yields zero to three
// edit words on the master side, each either an append of one code point (with its
// utf-8 bytes) or an erase of the last character; tlast marks the final word of a key.
// the front decodes a key and steps the composition state as the key is taken, so keys can
// be taken every cycle while a two-entry queue has room and no register write is offered;
// the back issues one edit word per cycle from the queue head while the receiver is ready.
// configuration writes are taken at once (cfg_ready is always high), hold off key words in
// the same cycle, and must only be issued while the block is idle.
module hangul_two_set_key_composer (
	input  wire         clk,
	input  wire         arst_n,
	// key input
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] key_code
	input  wire         s_tuser,   // [0] shift_held
	// edit output
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // [15:0] code_point, [39:16] utf8_code, [41:40] utf8_length
	output logic        m_tuser,   // [0] edit_op
	output logic        m_tlast,   // last word of this key
	// register writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire         cfg_data
);

	logic            push, full, pop, head_valid;
	hkc_pkg::entry_t push_entry, head_entry;
	logic [15:0]     cp;
	logic [23:0]     utf8;
	logic [1:0]      len;

	assign cfg_ready = 1'b1;
	// a register write wins over a key in the same cycle
	assign s_tready  = !full && !cfg_valid;

	hkc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (s_tvalid && s_tready),
		.key_code   (s_tdata),
		.shift_held (s_tuser),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_entry (push_entry)
	);

	// keys with results only; the queue decouples decode from output stalls
	hkc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	hkc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_op     (m_tuser),
		.out_cp     (cp),
		.out_utf8   (utf8),
		.out_len    (len),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'd0, len, utf8, cp};

endmodule
`default_nettype wire

// ===== src/hkc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hkc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  key_valid,
	input  wire  [7:0]           key_code,
	input  wire                  shift_held,
	input  wire                  cfg_we,
	input  wire  [7:0]           cfg_index,
	input  wire                  cfg_data,
	output logic                 push,
	output hkc_pkg::entry_t      push_entry
);

	logic                 numbers_only_q, numbers_allowed_q, mode_switch_q;
	hkc_pkg::input_mode_t mode_q, mode_d;
	hkc_pkg::level_t      level_q, level_d, lv;
	logic [4:0]           ini_q, med_q, fin_q, ini_d, med_d, fin_d;
	logic                 digit, letter;
	hkc_pkg::letter_t     li;
	logic [4:0]           t, i2f, fj, vj, f2i;
	logic [9:0]           split;

	assign digit  = (key_code >= 8'h30) && (key_code <= 8'h39);
	assign letter = (key_code >= 8'h61) && (key_code <= 8'h7A);
	assign li     = hkc_pkg::letter_info(5'(key_code - 8'h61), shift_held);
	assign t      = li.idx;
	assign i2f    = hkc_pkg::init_to_final(t);
	assign fj     = hkc_pkg::fin_join(fin_q, t);
	assign vj     = hkc_pkg::vow_join(med_q, t);
	assign f2i    = hkc_pkg::final_to_init(fin_q);
	assign split  = hkc_pkg::fin_split(fin_q);

	always_comb begin
		mode_d = mode_q;
		level_d = level_q;
		ini_d = ini_q;
		med_d = med_q;
		fin_d = fin_q;
		push = 1'b0;
		push_entry = '0;
		lv = (level_q == 3'd7) ? hkc_pkg::LV_IDLE : level_q;
		if (key_code == hkc_pkg::KeyTab) begin
			if (mode_switch_q) begin
				if (mode_q == hkc_pkg::MODE_HANGUL) begin
					level_d = hkc_pkg::LV_IDLE;
					mode_d = hkc_pkg::MODE_ENGLISH;
				end else begin
					mode_d = hkc_pkg::MODE_HANGUL;
				end
			end
		end else if (numbers_only_q) begin
			push_entry.cnt = 2'd1;
			if (digit) begin
				push = 1'b1;
				push_entry.cmd[0] = '{hkc_pkg::OP_APPEND, 16'(key_code)};
			end else if (key_code == hkc_pkg::KeyBackspace) begin
				push = 1'b1;
				push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
			end
		end else if (mode_q == hkc_pkg::MODE_ENGLISH) begin
			push_entry.cnt = 2'd1;
			if (key_code == hkc_pkg::KeySpace || (digit && numbers_allowed_q)) begin
				push = 1'b1;
				push_entry.cmd[0] = '{hkc_pkg::OP_APPEND, 16'(key_code)};
			end else if (letter) begin
				push = 1'b1;
				push_entry.cmd[0] = '{hkc_pkg::OP_APPEND,
					16'(shift_held ? key_code - 8'd32 : key_code)};
			end else if (key_code == hkc_pkg::KeyBackspace) begin
				push = 1'b1;
				push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
			end
		end else begin
			level_d = lv;
			if (key_code == hkc_pkg::KeySpace || (digit && numbers_allowed_q)) begin
				level_d = hkc_pkg::LV_IDLE;
				push = 1'b1;
				push_entry.cnt = 2'd1;
				push_entry.cmd[0] = '{hkc_pkg::OP_APPEND, 16'(key_code)};
			end else if (key_code == hkc_pkg::KeyBackspace) begin
				level_d = hkc_pkg::LV_IDLE;
				push = 1'b1;
				push_entry.cnt = 2'd1;
				push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
			end else if (letter) begin
				push = 1'b1;
				// command slots fill from cmd[0] upward
				if (!li.vowel) begin
					if ((lv == hkc_pkg::LV_MEDIAL || lv == hkc_pkg::LV_CMEDIAL) && i2f != 5'd0) begin
						fin_d = i2f;
						level_d = hkc_pkg::LV_FINAL;
						push_entry.cnt = 2'd2;
						push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
						push_entry.cmd[1] = '{hkc_pkg::OP_APPEND, hkc_pkg::syllable(ini_q, med_q, i2f)};
					end else if (lv == hkc_pkg::LV_FINAL && fj != 5'd0) begin
						fin_d = fj;
						level_d = hkc_pkg::LV_CFINAL;
						push_entry.cnt = 2'd2;
						push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
						push_entry.cmd[1] = '{hkc_pkg::OP_APPEND, hkc_pkg::syllable(ini_q, med_q, fj)};
					end else begin
						ini_d = t;
						level_d = hkc_pkg::LV_INITIAL;
						push_entry.cnt = 2'd1;
						push_entry.cmd[0] = '{hkc_pkg::OP_APPEND, hkc_pkg::cons_cp(t)};
					end
				end else if (lv == hkc_pkg::LV_INITIAL) begin
					med_d = t;
					level_d = hkc_pkg::LV_MEDIAL;
					push_entry.cnt = 2'd2;
					push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
					push_entry.cmd[1] = '{hkc_pkg::OP_APPEND, hkc_pkg::syllable(ini_q, t, 5'd0)};
				end else if (lv == hkc_pkg::LV_MEDIAL && vj != 5'd0) begin
					med_d = vj;
					level_d = hkc_pkg::LV_CMEDIAL;
					push_entry.cnt = 2'd2;
					push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
					push_entry.cmd[1] = '{hkc_pkg::OP_APPEND, hkc_pkg::syllable(ini_q, vj, 5'd0)};
				end else if (lv == hkc_pkg::LV_FINAL) begin
					// final consonant moves onto the new syllable
					ini_d = f2i;
					med_d = t;
					level_d = hkc_pkg::LV_MEDIAL;
					push_entry.cnt = 2'd3;
					push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
					push_entry.cmd[1] = '{hkc_pkg::OP_APPEND, hkc_pkg::syllable(ini_q, med_q, 5'd0)};
					push_entry.cmd[2] = '{hkc_pkg::OP_APPEND, hkc_pkg::syllable(f2i, t, 5'd0)};
				end else if (lv == hkc_pkg::LV_CFINAL) begin
					fin_d = split[9:5];
					ini_d = split[4:0];
					med_d = t;
					level_d = hkc_pkg::LV_MEDIAL;
					push_entry.cnt = 2'd3;
					push_entry.cmd[0] = '{hkc_pkg::OP_ERASE, 16'd0};
					push_entry.cmd[1] = '{hkc_pkg::OP_APPEND,
						hkc_pkg::syllable(ini_q, med_q, split[9:5])};
					push_entry.cmd[2] = '{hkc_pkg::OP_APPEND,
						hkc_pkg::syllable(split[4:0], t, 5'd0)};
				end else begin
					med_d = t;
					level_d = hkc_pkg::LV_VOWEL;
					push_entry.cnt = 2'd1;
					push_entry.cmd[0] = '{hkc_pkg::OP_APPEND, hkc_pkg::VowelBase + 16'(t)};
				end
			end
		end
		if (!key_valid) begin
			push = 1'b0;
		end
	end

	// start_mode only acts at the moment it is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numbers_only_q <= 1'b0;
			numbers_allowed_q <= 1'b1;
			mode_switch_q <= 1'b1;
			mode_q <= hkc_pkg::MODE_HANGUL;
			level_q <= hkc_pkg::LV_IDLE;
			ini_q <= '0;
			med_q <= '0;
			fin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				8'(hkc_pkg::RegNumbersOnly):    numbers_only_q <= cfg_data;
				8'(hkc_pkg::RegNumbersAllowed): numbers_allowed_q <= cfg_data;
				8'(hkc_pkg::RegModeSwitch):     mode_switch_q <= cfg_data;
				8'(hkc_pkg::RegStartMode): begin
					mode_q <= hkc_pkg::input_mode_t'(cfg_data);
					level_q <= hkc_pkg::LV_IDLE;
				end
				default: ;
			endcase
		end else if (key_valid) begin
			mode_q <= mode_d;
			level_q <= level_d;
			ini_q <= ini_d;
			med_q <= med_d;
			fin_q <= fin_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/hkc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hkc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  hkc_pkg::entry_t      push_entry,
	output logic                 full,
	input  wire                  pop,
	output logic                 head_valid,
	output hkc_pkg::entry_t      head_entry
);

	hkc_pkg::entry_t mem_q [2];
	logic            wr_q, rd_q;
	logic [1:0]      count_q;

	assign full = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== src/hkc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hkc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  hkc_pkg::entry_t      head_entry,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic                 out_op,
	output logic [15:0]          out_cp,
	output logic [23:0]          out_utf8,
	output logic [1:0]           out_len,
	output logic                 out_last
);

	logic [1:0]    idx_q;
	logic          load, last;
	hkc_pkg::cmd_t cur;
	logic [23:0]   code;
	logic [1:0]    len;

	assign cur  = head_entry.cmd[idx_q];
	assign last = idx_q == head_entry.cnt - 2'd1;
	assign load = head_valid && (!out_valid || out_ready);
	assign pop  = load && last;

	always_comb begin
		if (cur.op == hkc_pkg::OP_ERASE) begin
			code = '0;
			len = 2'd0;
		end else if (cur.cp < 16'h0080) begin
			code = 24'(cur.cp);
			len = 2'd1;
		end else if (cur.cp < 16'h0800) begin
			code = {8'd0, 3'b110, cur.cp[10:6], 2'b10, cur.cp[5:0]};
			len = 2'd2;
		end else begin
			code = {4'hE, cur.cp[15:12], 2'b10, cur.cp[11:6], 2'b10, cur.cp[5:0]};
			len = 2'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_op <= cur.op;
			out_cp <= (cur.op == hkc_pkg::OP_ERASE) ? 16'd0 : cur.cp;
			out_utf8 <= code;
			out_len <= len;
			out_last <= last;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] key_code
	logic        s_tuser;   // [0] shift_held
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // [15:0] code_point, [39:16] utf8_code, [41:40] utf8_length
	logic        m_tuser;   // [0] edit_op
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic        cfg_data;

	hangul_two_set_key_composer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// one expected edit word
	typedef struct {
		hkc_pkg::edit_op_t op;
		logic [15:0]       cp;
		logic [23:0]       utf8;
		logic [1:0]        len;
		logic              last;
	} edit_word_t;

	edit_word_t pending_edits[$];
	int         errors;
	int         edits_seen;

	// shadow of the registers and the composer state
	logic                 sh_numbers_only, sh_numbers_allowed, sh_mode_switch;
	hkc_pkg::input_mode_t sh_mode;
	hkc_pkg::level_t      sh_level;
	logic [4:0]           sh_init, sh_med, sh_fin;
	edit_word_t           key_edits[$];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------- prediction
	// lookups kept local so the check does not lean on the design's own tables

	function automatic logic [15:0] jamo_cons(input logic [4:0] t);
		logic [15:0] tbl [0:18];
		tbl = '{16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
			16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
			16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E};
		return tbl[t % 19];
	endfunction

	function automatic logic [4:0] as_final(input logic [4:0] t);
		logic [4:0] tbl [0:18];
		tbl = '{5'd1, 5'd2, 5'd4, 5'd7, 5'd0, 5'd8, 5'd16, 5'd17, 5'd0, 5'd19, 5'd20,
			5'd21, 5'd22, 5'd0, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27};
		return (t < 19) ? tbl[t] : 5'd0;
	endfunction

	function automatic logic [4:0] as_initial(input logic [4:0] f);
		logic [4:0] tbl [0:27];
		tbl = '{5'd0, 5'd0, 5'd1, 5'd0, 5'd2, 5'd0, 5'd0, 5'd3, 5'd5, 5'd0, 5'd0, 5'd0,
			5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd7, 5'd0, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14,
			5'd15, 5'd16, 5'd17, 5'd18};
		return tbl[f % 28];
	endfunction

	// compound finals as {first, added, compound}
	function automatic logic [14:0] cfin_row(input int i);
		logic [14:0] tbl [0:10];
		tbl = '{{5'd1, 5'd9, 5'd3}, {5'd4, 5'd12, 5'd5}, {5'd4, 5'd18, 5'd6},
			{5'd8, 5'd0, 5'd9}, {5'd8, 5'd6, 5'd10}, {5'd8, 5'd7, 5'd11},
			{5'd8, 5'd9, 5'd12}, {5'd8, 5'd16, 5'd13}, {5'd8, 5'd17, 5'd14},
			{5'd8, 5'd18, 5'd15}, {5'd17, 5'd9, 5'd18}};
		return tbl[i];
	endfunction

	function automatic logic [14:0] cvow_row(input int i);
		logic [14:0] tbl [0:6];
		tbl = '{{5'd8, 5'd0, 5'd9}, {5'd8, 5'd1, 5'd10}, {5'd8, 5'd20, 5'd11},
			{5'd13, 5'd4, 5'd14}, {5'd13, 5'd5, 5'd15}, {5'd13, 5'd20, 5'd16},
			{5'd18, 5'd20, 5'd19}};
		return tbl[i];
	endfunction

	// letter a-z: {vowel, plain index, shifted index}
	function automatic logic [10:0] key_jamo(input int l);
		logic [10:0] tbl [0:25];
		tbl = '{{1'b0, 5'd6, 5'd6}, {1'b1, 5'd17, 5'd17}, {1'b0, 5'd14, 5'd14},
			{1'b0, 5'd11, 5'd11}, {1'b0, 5'd3, 5'd4}, {1'b0, 5'd5, 5'd5},
			{1'b0, 5'd18, 5'd18}, {1'b1, 5'd8, 5'd8}, {1'b1, 5'd2, 5'd2},
			{1'b1, 5'd4, 5'd4}, {1'b1, 5'd0, 5'd0}, {1'b1, 5'd20, 5'd20},
			{1'b1, 5'd18, 5'd18}, {1'b1, 5'd13, 5'd13}, {1'b1, 5'd1, 5'd3},
			{1'b1, 5'd5, 5'd7}, {1'b0, 5'd7, 5'd8}, {1'b0, 5'd0, 5'd1},
			{1'b0, 5'd2, 5'd2}, {1'b0, 5'd9, 5'd10}, {1'b1, 5'd6, 5'd6},
			{1'b0, 5'd17, 5'd17}, {1'b0, 5'd12, 5'd13}, {1'b0, 5'd16, 5'd16},
			{1'b1, 5'd12, 5'd12}, {1'b0, 5'd15, 5'd15}};
		return tbl[l];
	endfunction

	function automatic logic [15:0] block_of(input logic [4:0] a, input logic [4:0] b,
		input logic [4:0] c);
		return 16'hAC00 + 16'(a) * 16'd588 + 16'(b) * 16'd28 + 16'(c);
	endfunction

	task automatic push_edit(input hkc_pkg::edit_op_t op, input logic [15:0] cp);
		edit_word_t w;
		w.op   = op;
		w.last = 1'b0;
		if (op == hkc_pkg::OP_ERASE) begin
			w.cp = '0; w.utf8 = '0; w.len = 2'd0;
		end else begin
			w.cp = cp;
			if (cp < 16'h80) begin
				w.utf8 = {8'd0, 8'd0, cp[7:0]}; w.len = 2'd1;
			end else if (cp < 16'h800) begin
				w.utf8 = {8'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]}; w.len = 2'd2;
			end else begin
				w.utf8 = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
				w.len = 2'd3;
			end
		end
		key_edits.insert(key_edits.size(), w);
	endtask

	// consonant key in hangul mode
	task automatic compose_consonant(input logic [4:0] t);
		if ((sh_level == hkc_pkg::LV_MEDIAL || sh_level == hkc_pkg::LV_CMEDIAL)
				&& as_final(t) != 5'd0) begin
			sh_fin = as_final(t);
			push_edit(hkc_pkg::OP_ERASE, 16'd0);
			push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, sh_fin));
			sh_level = hkc_pkg::LV_FINAL;
			return;
		end
		if (sh_level == hkc_pkg::LV_FINAL) begin
			for (int i = 0; i < 11; i++) begin
				if (cfin_row(i)[14:10] == sh_fin && cfin_row(i)[9:5] == t) begin
					sh_fin = cfin_row(i)[4:0];
					push_edit(hkc_pkg::OP_ERASE, 16'd0);
					push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, sh_fin));
					sh_level = hkc_pkg::LV_CFINAL;
					return;
				end
			end
		end
		sh_init  = t;
		sh_level = hkc_pkg::LV_INITIAL;
		push_edit(hkc_pkg::OP_APPEND, jamo_cons(t));
	endtask

	// vowel key in hangul mode
	task automatic compose_vowel(input logic [4:0] t);
		logic [4:0] first, moved;
		case (sh_level)
			hkc_pkg::LV_INITIAL: begin
				sh_med = t;
				push_edit(hkc_pkg::OP_ERASE, 16'd0);
				push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, 5'd0));
				sh_level = hkc_pkg::LV_MEDIAL;
				return;
			end
			hkc_pkg::LV_MEDIAL: begin
				for (int i = 0; i < 7; i++) begin
					if (cvow_row(i)[14:10] == sh_med && cvow_row(i)[9:5] == t) begin
						sh_med = cvow_row(i)[4:0];
						push_edit(hkc_pkg::OP_ERASE, 16'd0);
						push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, 5'd0));
						sh_level = hkc_pkg::LV_CMEDIAL;
						return;
					end
				end
			end
			hkc_pkg::LV_FINAL: begin
				// the final moves over to start the next syllable
				push_edit(hkc_pkg::OP_ERASE, 16'd0);
				push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, 5'd0));
				sh_init = as_initial(sh_fin);
				sh_med  = t;
				push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, 5'd0));
				sh_level = hkc_pkg::LV_MEDIAL;
				return;
			end
			hkc_pkg::LV_CFINAL: begin
				// only the second half of the compound final moves over
				first = sh_fin;
				moved = '0;
				for (int i = 0; i < 11; i++) begin
					if (cfin_row(i)[4:0] == sh_fin) begin
						first = cfin_row(i)[14:10];
						moved = cfin_row(i)[9:5];
						break;
					end
				end
				sh_fin = first;
				push_edit(hkc_pkg::OP_ERASE, 16'd0);
				push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, sh_fin));
				sh_init = moved;
				sh_med  = t;
				push_edit(hkc_pkg::OP_APPEND, block_of(sh_init, sh_med, 5'd0));
				sh_level = hkc_pkg::LV_MEDIAL;
				return;
			end
			default: ;
		endcase
		sh_med   = t;
		sh_level = hkc_pkg::LV_VOWEL;
		push_edit(hkc_pkg::OP_APPEND, 16'h314F + 16'(t));
	endtask

	// works out the edit words of one key and queues them
	task automatic predict_key_edits(input logic [7:0] key, input logic shift);
		logic        digit, letter;
		logic [10:0] lj;
		key_edits.delete();
		digit  = key >= "0" && key <= "9";
		letter = key >= "a" && key <= "z";
		if (key == hkc_pkg::KeyTab) begin
			if (sh_mode_switch) begin
				if (sh_mode == hkc_pkg::MODE_HANGUL) begin
					sh_level = hkc_pkg::LV_IDLE;
					sh_mode  = hkc_pkg::MODE_ENGLISH;
				end else begin
					sh_mode = hkc_pkg::MODE_HANGUL;
				end
			end
		end else if (sh_numbers_only) begin
			if (digit) push_edit(hkc_pkg::OP_APPEND, 16'(key));
			else if (key == hkc_pkg::KeyBackspace) push_edit(hkc_pkg::OP_ERASE, 16'd0);
		end else if (sh_mode == hkc_pkg::MODE_ENGLISH) begin
			if (key == hkc_pkg::KeySpace) push_edit(hkc_pkg::OP_APPEND, 16'(key));
			else if (letter)
				push_edit(hkc_pkg::OP_APPEND, shift ? 16'(key - 8'd32) : 16'(key));
			else if (key == hkc_pkg::KeyBackspace) push_edit(hkc_pkg::OP_ERASE, 16'd0);
			else if (digit && sh_numbers_allowed) push_edit(hkc_pkg::OP_APPEND, 16'(key));
		end else begin
			if (sh_level == 3'd7) sh_level = hkc_pkg::LV_IDLE;
			if (key == hkc_pkg::KeySpace || (digit && sh_numbers_allowed)) begin
				sh_level = hkc_pkg::LV_IDLE;
				push_edit(hkc_pkg::OP_APPEND, 16'(key));
			end else if (letter) begin
				lj = key_jamo(key - "a");
				if (lj[10]) compose_vowel(shift ? lj[4:0] : lj[9:5]);
				else compose_consonant(shift ? lj[4:0] : lj[9:5]);
			end else if (key == hkc_pkg::KeyBackspace) begin
				sh_level = hkc_pkg::LV_IDLE;
				push_edit(hkc_pkg::OP_ERASE, 16'd0);
			end
		end
		if (key_edits.size() > 0) key_edits[key_edits.size() - 1].last = 1'b1;
		pending_edits = {pending_edits, key_edits};
	endtask

	// ---------------------------------------------------------------- drivers

	int burst_left;
	int stall_pattern;

	// sends one key word, with bursts and random gaps before it
	task automatic send_key(input logic [7:0] key, input logic shift);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		s_tuser  <= shift;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_key_edits(key, shift);
	endtask

	// receiver stalls follow a pattern that changes now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready      <= 1'b0;
			stall_pattern <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_pattern <= $urandom_range(0, 3);
			case (stall_pattern)
				0: m_tready <= 1'b1;
				1: m_tready <= ~m_tready;
				2: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// compares each edit word with the oldest expectation
	always @(posedge clk) begin
		edit_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			edits_seen++;
			if (pending_edits.size() == 0) begin
				$display("%0t: unexpected edit word op=%0d cp=%h", $time, m_tuser,
					m_tdata[15:0]);
				errors++;
			end else begin
				w = pending_edits.pop_front();
				if (m_tuser !== w.op || m_tdata[15:0] !== w.cp
						|| m_tdata[39:16] !== w.utf8 || m_tdata[41:40] !== w.len
						|| m_tdata[47:42] !== 6'd0 || m_tlast !== w.last) begin
					$display("%0t: expected op=%0d cp=%h utf8=%h len=%0d last=%0d",
						$time, w.op, w.cp, w.utf8, w.len, w.last);
					$display("%0t: actual   op=%0d cp=%h utf8=%h len=%0d last=%0d",
						$time, m_tuser, m_tdata[15:0], m_tdata[39:16], m_tdata[41:40],
						m_tlast);
					errors++;
				end
			end
		end
	end

	// drains the output and lets a trailing key finish; write_reg then writes one register
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_edits.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= 8'(idx);
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			hkc_pkg::RegNumbersOnly:    sh_numbers_only = value;
			hkc_pkg::RegNumbersAllowed: sh_numbers_allowed = value;
			hkc_pkg::RegModeSwitch:     sh_mode_switch = value;
			default: begin
				sh_mode  = hkc_pkg::input_mode_t'(value);
				sh_level = hkc_pkg::LV_IDLE;
			end
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// typing "gksrmf" style sequences: whole syllables and final splits
	task automatic test_hangul_directed;
		logic [7:0] keys [0:17];
		keys = '{"r", "k", "s", "k", "f", "r", "k", "d", "h", "d", "k", "f", "q", "k",
			"q", "t", "k", "m"};
		foreach (keys[i]) send_key(keys[i], 1'b0);
		// tense consonants and shifted vowels, compound vowels
		send_key("r", 1'b1); send_key("h", 1'b0); send_key("k", 1'b0);
		send_key("o", 1'b1); send_key(hkc_pkg::KeySpace, 1'b0); send_key("7", 1'b1);
		send_key(hkc_pkg::KeyBackspace, 1'b0); send_key("A", 1'b0); send_key(8'hFF, 1'b1);
	endtask

	task automatic test_english_and_tab;
		send_key("g", 1'b0); send_key(hkc_pkg::KeyTab, 1'b0);
		send_key("a", 1'b0); send_key("z", 1'b1); send_key("0", 1'b0);
		send_key(hkc_pkg::KeySpace, 1'b1); send_key(hkc_pkg::KeyBackspace, 1'b1);
		send_key(8'h00, 1'b0);
		send_key(hkc_pkg::KeyTab, 1'b1);
	endtask

	task automatic test_registers;
		write_reg(hkc_pkg::RegNumbersAllowed, 1'b0);
		send_key("5", 1'b0); send_key("9", 1'b0); send_key("a", 1'b0);
		write_reg(hkc_pkg::RegNumbersOnly, 1'b1);
		send_key("9", 1'b0); send_key("a", 1'b0); send_key(hkc_pkg::KeyBackspace, 1'b0);
		send_key(hkc_pkg::KeyTab, 1'b0); send_key("1", 1'b1);
		write_reg(hkc_pkg::RegModeSwitch, 1'b0);
		send_key(hkc_pkg::KeyTab, 1'b0);
		write_reg(hkc_pkg::RegNumbersOnly, 1'b0);
		send_key("q", 1'b1);
		write_reg(hkc_pkg::RegStartMode, 1'b1);
		send_key("r", 1'b0); send_key(hkc_pkg::KeyTab, 1'b0);
		write_reg(hkc_pkg::RegStartMode, 1'b0);
		write_reg(hkc_pkg::RegModeSwitch, 1'b1);
		write_reg(hkc_pkg::RegNumbersAllowed, 1'b1);
	endtask

	// mostly letters so syllables build deep, with some noise keys
	task automatic test_random_typing(input int count);
		logic [7:0] key;
		int         pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) key = 8'("a" + $urandom_range(0, 25));
			else if (pick < 85) key = 8'("0" + $urandom_range(0, 9));
			else if (pick < 89) key = hkc_pkg::KeySpace;
			else if (pick < 93) key = hkc_pkg::KeyBackspace;
			else if (pick < 95) key = hkc_pkg::KeyTab;
			else key = 8'($urandom_range(0, 255));
			send_key(key, ($urandom_range(0, 3) == 0));
		end
	endtask

	task automatic test_random_settings;
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(hkc_pkg::RegNumbersAllowed, 1'($urandom_range(0, 1)));
			write_reg(hkc_pkg::RegModeSwitch, 1'($urandom_range(0, 1)));
			write_reg(hkc_pkg::RegStartMode, 1'($urandom_range(0, 1)));
			write_reg(hkc_pkg::RegNumbersOnly, (phase == 3));
			test_random_typing(30);
		end
		write_reg(hkc_pkg::RegNumbersOnly, 1'b0);
		write_reg(hkc_pkg::RegModeSwitch, 1'b1);
		write_reg(hkc_pkg::RegStartMode, 1'b0);
		test_random_typing(100);
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = 1'b0;
		errors    = 0;
		edits_seen = 0;
		burst_left = 0;
		sh_numbers_only    = 1'b0;
		sh_numbers_allowed = 1'b1;
		sh_mode_switch     = 1'b1;
		sh_mode  = hkc_pkg::MODE_HANGUL;
		sh_level = hkc_pkg::LV_IDLE;
		sh_init  = '0;
		sh_med   = '0;
		sh_fin   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hangul_directed();
		test_english_and_tab();
		test_registers();
		test_random_settings();

		drain();
		if (errors == 0 && pending_edits.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
